FILE: hw/rtl/alsort_pkg.sv
// Shared types and constants for the ordered list store with insertion sort.
package alsort_pkg;

  // Fixed field widths of the request and response channels
  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 8;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_REPLACE = 3'd3,
    OP_SORT    = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  // Response status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } stat_e;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_PLACE,
    S_READ,
    S_SORT_KEY,
    S_SORT_LD,
    S_SORT_CMP,
    S_SORT_PUT,
    S_RESP
  } state_e;

endpackage

FILE: hw/rtl/alsort_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module alsort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/array_list_store_sort_top.sv
// Top level: ordered list store with request sequencer and entry RAM.
//
//   channel   direction  handshake               payload
//   request   in         in_valid_i / in_stall_o   op_i, position_i, value_i
//   response  out        out_valid_o / out_stall_i status_o, read_value_o, entry_count_o
//
// One request is worked at a time; the single-port-pair entry RAM sets the pace.
// Insert and delete shift the later entries one place over, with one RAM read and
// one write per cycle, then drain the last write; sort is quadratic in the worst case.
// Reset clears the count and control; the RAM contents are not cleared.
// A stalled response holds in the output register; the next request is still taken.
module array_list_store_sort_top #(
  parameter int unsigned DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [6:0]  position_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] read_value_o,
  output logic [7:0]  entry_count_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = alsort_pkg::POS_W;
  localparam int unsigned VAL_W = alsort_pkg::VAL_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  alsort_pkg::state_e state_q, state_d;

  logic [alsort_pkg::OP_W-1:0] op_q, op_d;
  logic [POS_W-1:0]            pos_q, pos_d;
  logic [VAL_W-1:0]            val_q, val_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic                        more_q, more_d;
  logic                        pend_q, pend_d;
  logic [AW-1:0]               pend_addr_q, pend_addr_d;
  logic [CW-1:0]               i_q, i_d;
  logic [AW-1:0]               j_q, j_d;
  logic [VAL_W-1:0]            key_q, key_d;
  alsort_pkg::stat_e           res_stat_q, res_stat_d;
  logic [VAL_W-1:0]            res_rd_q, res_rd_d;

  logic                        out_valid_q, out_valid_d;
  logic [alsort_pkg::STAT_W-1:0] out_stat_q, out_stat_d;
  logic [VAL_W-1:0]            out_rd_q, out_rd_d;
  logic [alsort_pkg::COUNT_W-1:0] out_cnt_q, out_cnt_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [VAL_W-1:0]            ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [VAL_W-1:0]            ram_rdata;

  logic [CW+POS_W-1:0]         pos_ext;
  logic [CW+POS_W-1:0]         cnt_ext;
  logic [AW-1:0]               pos_a;
  logic [CW-1:0]               cnt_m1;
  logic [AW-1:0]               last_a;
  logic [CW-1:0]               i_p1;
  logic [CW+alsort_pkg::COUNT_W-1:0] cnt_wide;
  logic                        pos_bad;
  logic                        is_ins;
  logic                        out_free;

  // Common index arithmetic
  assign pos_ext  = {{CW{1'b0}}, pos_q};
  assign cnt_ext  = {{POS_W{1'b0}}, cnt_q};
  assign pos_a    = pos_ext[AW-1:0];
  assign cnt_m1   = cnt_q - 1'b1;
  assign last_a   = cnt_m1[AW-1:0];
  assign i_p1     = i_q + 1'b1;
  assign cnt_wide = {{alsort_pkg::COUNT_W{1'b0}}, cnt_q};
  assign pos_bad  = (pos_ext >= cnt_ext);
  assign is_ins   = (op_q == alsort_pkg::OP_INSERT);
  assign out_free = !out_valid_q || !out_stall_i;

  alsort_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: next state, RAM access and response staging
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    more_d      = more_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    i_d         = i_q;
    j_d         = j_q;
    key_d       = key_q;
    res_stat_d  = res_stat_q;
    res_rd_d    = res_rd_q;
    out_valid_d = out_valid_q;
    out_stat_d  = out_stat_q;
    out_rd_d    = out_rd_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;

    // Drop the response once transferred
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      alsort_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_i;
          pos_d   = position_i;
          val_d   = value_i;
          state_d = alsort_pkg::S_EXEC;
        end
      end

      alsort_pkg::S_EXEC: begin
        res_stat_d = alsort_pkg::ST_OK;
        res_rd_d   = '0;
        state_d    = alsort_pkg::S_RESP;
        case (alsort_pkg::op_e'(op_q))
          alsort_pkg::OP_APPEND: begin
            if (cnt_q == FULL_CNT) begin
              res_stat_d = alsort_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = cnt_q[AW-1:0];
              ram_wdata = val_q;
              cnt_d     = cnt_q + 1'b1;
            end
          end
          alsort_pkg::OP_INSERT: begin
            if (cnt_q == FULL_CNT) begin
              res_stat_d = alsort_pkg::ST_FULL;
            end else if (pos_ext > cnt_ext) begin
              res_stat_d = alsort_pkg::ST_BADPOS;
            end else if (pos_ext == cnt_ext) begin
              ram_we    = 1'b1;
              ram_waddr = pos_a;
              ram_wdata = val_q;
              cnt_d     = cnt_q + 1'b1;
            end else begin
              // Move entries up, starting from the last one
              idx_d   = last_a;
              more_d  = 1'b1;
              pend_d  = 1'b0;
              state_d = alsort_pkg::S_SHIFT;
            end
          end
          alsort_pkg::OP_DELETE: begin
            if (pos_bad) begin
              res_stat_d = alsort_pkg::ST_BADPOS;
            end else if (pos_ext + 1'b1 == cnt_ext) begin
              cnt_d = cnt_m1;
            end else begin
              // Move entries down, starting just above the hole
              idx_d   = pos_a + 1'b1;
              more_d  = 1'b1;
              pend_d  = 1'b0;
              state_d = alsort_pkg::S_SHIFT;
            end
          end
          alsort_pkg::OP_REPLACE: begin
            if (pos_bad) begin
              res_stat_d = alsort_pkg::ST_BADPOS;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pos_a;
              ram_wdata = val_q;
            end
          end
          alsort_pkg::OP_SORT: begin
            if (cnt_q > CW'(1)) begin
              i_d     = CW'(1);
              state_d = alsort_pkg::S_SORT_KEY;
            end
          end
          alsort_pkg::OP_READ: begin
            if (pos_bad) begin
              res_stat_d = alsort_pkg::ST_BADPOS;
            end else begin
              ram_raddr = pos_a;
              state_d   = alsort_pkg::S_READ;
            end
          end
          default: begin
          end
        endcase
      end

      alsort_pkg::S_SHIFT: begin
        // Write back the entry read last cycle, one place over
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_q;
          ram_wdata = ram_rdata;
        end
        if (more_q) begin
          ram_raddr   = idx_q;
          pend_d      = 1'b1;
          pend_addr_d = is_ins ? idx_q + 1'b1 : idx_q - 1'b1;
          if (is_ins ? (idx_q == pos_a) : (idx_q == last_a)) begin
            more_d = 1'b0;
          end else begin
            idx_d = is_ins ? idx_q - 1'b1 : idx_q + 1'b1;
          end
        end else begin
          pend_d = 1'b0;
          if (is_ins) begin
            state_d = alsort_pkg::S_PLACE;
          end else begin
            cnt_d   = cnt_m1;
            state_d = alsort_pkg::S_RESP;
          end
        end
      end

      alsort_pkg::S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_a;
        ram_wdata = val_q;
        cnt_d     = cnt_q + 1'b1;
        state_d   = alsort_pkg::S_RESP;
      end

      alsort_pkg::S_READ: begin
        res_rd_d = ram_rdata;
        state_d  = alsort_pkg::S_RESP;
      end

      alsort_pkg::S_SORT_KEY: begin
        ram_raddr = i_q[AW-1:0];
        state_d   = alsort_pkg::S_SORT_LD;
      end

      alsort_pkg::S_SORT_LD: begin
        key_d     = ram_rdata;
        j_d       = i_q[AW-1:0];
        ram_raddr = i_q[AW-1:0] - 1'b1;
        state_d   = alsort_pkg::S_SORT_CMP;
      end

      alsort_pkg::S_SORT_CMP: begin
        if ($signed(ram_rdata) > $signed(key_q)) begin
          // Shift the larger entry up and look one further down
          ram_we    = 1'b1;
          ram_waddr = j_q;
          ram_wdata = ram_rdata;
          j_d       = j_q - 1'b1;
          if (j_q == AW'(1)) begin
            state_d = alsort_pkg::S_SORT_PUT;
          end else begin
            ram_raddr = j_q - AW'(2);
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = j_q;
          ram_wdata = key_q;
          if (i_p1 >= cnt_q) begin
            state_d = alsort_pkg::S_RESP;
          end else begin
            i_d     = i_p1;
            state_d = alsort_pkg::S_SORT_KEY;
          end
        end
      end

      alsort_pkg::S_SORT_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = key_q;
        if (i_p1 >= cnt_q) begin
          state_d = alsort_pkg::S_RESP;
        end else begin
          i_d     = i_p1;
          state_d = alsort_pkg::S_SORT_KEY;
        end
      end

      alsort_pkg::S_RESP: begin
        // Load the output register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_rd_d    = res_rd_q;
          out_cnt_d   = cnt_wide[alsort_pkg::COUNT_W-1:0];
          state_d     = alsort_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = alsort_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alsort_pkg::S_IDLE;
      cnt_q       <= '0;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and index registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    idx_q       <= idx_d;
    pend_addr_q <= pend_addr_d;
    i_q         <= i_d;
    j_q         <= j_d;
    key_q       <= key_d;
    res_stat_q  <= res_stat_d;
    res_rd_q    <= res_rd_d;
    out_stat_q  <= out_stat_d;
    out_rd_q    <= out_rd_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign in_stall_o    = (state_q != alsort_pkg::S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_stat_q;
  assign read_value_o  = out_rd_q;
  assign entry_count_o = out_cnt_q;

endmodule
